@@ hdl/wfpa_pkg.sv @@
// Shared types and constants for the worst-fit partition allocator.
package wfpa_pkg;

  localparam int MAX_PARTS_DEF = 16;
  localparam int SIZE_BITS_DEF = 16;
  localparam int FIELD_W = 16;
  localparam int ID_W = 16;
  localparam int STATUS_W = 3;
  localparam logic [FIELD_W-1:0] TOTAL_RESET = 16'd4096;

  typedef enum logic {
    OP_ALLOC = 1'b0,
    OP_FREE  = 1'b1
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_ALLOCATED = 3'd0,
    ST_NO_FIT    = 3'd1,
    ST_FULL      = 3'd2,
    ST_FREED     = 3'd3,
    ST_NO_ID     = 3'd4,
    ST_ZERO      = 3'd5
  } status_t;

  typedef struct packed {
    logic    init;
    logic    load;
    logic    scan;
    logic    up_init;
    logic    up;
    logic    split;
    logic    place;
    logic    fnext;
    logic    merge;
    logic    down;
    logic    set_st;
    status_t st;
    logic    load_out;
  } cmd_t;

  typedef struct packed {
    logic in_zero;
    logic op_free;
    logic match;
    logic fwd_done;
    logic up_done;
    logic found;
    logic exact;
    logic full;
  } flag_t;

endpackage

@@ hdl/wfpa_req_if.sv @@
// Request channel interface: operation, size and owner id.
interface wfpa_req_if import wfpa_pkg::*; ();
  logic                valid;
  logic                ready;
  logic                op;
  logic [FIELD_W-1:0]  request_size;
  logic [ID_W-1:0]     owner_id;

  modport source (output valid, output op, output request_size, output owner_id,
                  input ready);
  modport sink (input valid, input op, input request_size, input owner_id,
                output ready);
endinterface

@@ hdl/wfpa_rsp_if.sv @@
// Response channel interface: status, id and granted size.
interface wfpa_rsp_if import wfpa_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [ID_W-1:0]     result_id;
  logic [FIELD_W-1:0]  granted_size;

  modport source (output valid, output status, output result_id, output granted_size,
                  input ready);
  modport sink (input valid, input status, input result_id, input granted_size,
                output ready);
endinterface

@@ hdl/wfpa_dp.sv @@
// Datapath of the allocator: partition table memory, scan, shift and merge registers.
module wfpa_dp import wfpa_pkg::*; #(
  parameter int MAX_PARTS = MAX_PARTS_DEF,
  parameter int SIZE_BITS = SIZE_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic [FIELD_W-1:0]  cfg_data,
  input  logic                op,
  input  logic [FIELD_W-1:0]  request_size,
  input  logic [ID_W-1:0]     owner_id,
  input  cmd_t                cmd,
  output flag_t               flag,
  output logic [STATUS_W-1:0] status,
  output logic [ID_W-1:0]     result_id,
  output logic [FIELD_W-1:0]  granted_size
);

  localparam int PB = (MAX_PARTS > 1) ? $clog2(MAX_PARTS) : 1;
  localparam int CW = $clog2(MAX_PARTS + 1);

  typedef struct packed {
    logic                 used;
    logic [ID_W-1:0]      owner;
    logic [SIZE_BITS-1:0] size;
  } part_t;

  part_t                mem [MAX_PARTS];
  part_t                rdata;
  part_t                wdata;
  logic                 ren;
  logic                 we;
  logic [PB-1:0]        raddr;
  logic [PB-1:0]        waddr;

  logic [FIELD_W-1:0]   total;
  logic [CW-1:0]        count;
  logic [ID_W-1:0]      next_id;
  logic [CW-1:0]        ptr;
  logic                 rd_vld;
  logic                 found;

  logic                 op_free;
  logic [SIZE_BITS-1:0] req_sz;
  logic [ID_W-1:0]      who;
  logic [ID_W-1:0]      rid;
  logic [CW-1:0]        rd_idx;
  logic [PB-1:0]        best;
  logic [SIZE_BITS-1:0] best_left;
  logic                 prev_used;
  logic [SIZE_BITS-1:0] prev_size;
  logic [PB-1:0]        k;
  logic                 prev_free;
  logic [SIZE_BITS-1:0] acc;
  logic [PB-1:0]        start;
  logic [1:0]           shift_d;
  status_t              status_r;
  logic [SIZE_BITS-1:0] granted_r;

  logic [SIZE_BITS-1:0] in_req;
  logic [SIZE_BITS-1:0] rd_left;
  logic                 fwd_issue;
  logic                 up_issue;
  logic                 take;
  logic                 match;
  logic                 nxt_free;
  logic                 down_done;
  logic [CW-1:0]        up_dst;
  logic [CW-1:0]        down_dst;
  logic [PB-1:0]        best_nx;

  assign in_req    = SIZE_BITS'(request_size);
  assign rd_left   = rdata.size - req_sz;
  assign fwd_issue = ptr < count;
  assign up_issue  = ptr > CW'(best);
  assign take      = cmd.scan && rd_vld && !op_free && !rdata.used &&
                     (rdata.size >= req_sz) && (!found || (rd_left > best_left));
  assign match     = cmd.scan && rd_vld && op_free && rdata.used && (rdata.owner == who);
  assign nxt_free  = rd_vld && !rdata.used;
  assign down_done = cmd.down && !fwd_issue && !rd_vld;
  assign up_dst    = rd_idx + CW'(1);
  assign down_dst  = rd_idx - CW'(shift_d);
  assign best_nx   = best + PB'(1);

  always_comb begin
    flag.in_zero  = (op == OP_ALLOC) && (in_req == '0);
    flag.op_free  = op_free;
    flag.match    = match;
    flag.fwd_done = !fwd_issue && !rd_vld;
    flag.up_done  = !up_issue && !rd_vld;
    flag.found    = found;
    flag.exact    = (best_left == '0);
    flag.full     = (count >= CW'(MAX_PARTS));
  end

  always_comb begin
    ren   = 1'b0;
    raddr = ptr[PB-1:0];
    we    = 1'b0;
    waddr = '0;
    wdata = '0;
    if (cmd.scan || cmd.down) begin
      ren = fwd_issue;
    end
    if (cmd.up) begin
      ren = up_issue;
    end
    priority if (cmd.init) begin
      we         = 1'b1;
      waddr      = '0;
      wdata.size = SIZE_BITS'(total);
    end else if (cmd.up) begin
      we    = rd_vld;
      waddr = up_dst[PB-1:0];
      wdata = rdata;
    end else if (cmd.split) begin
      we         = 1'b1;
      waddr      = best_nx;
      wdata.size = best_left;
    end else if (cmd.place) begin
      we          = 1'b1;
      waddr       = best;
      wdata.used  = 1'b1;
      wdata.owner = rid;
      wdata.size  = req_sz;
    end else if (cmd.merge) begin
      we         = 1'b1;
      waddr      = start;
      wdata.size = acc;
    end else if (cmd.down) begin
      we    = rd_vld;
      waddr = down_dst[PB-1:0];
      wdata = rdata;
    end else begin
      we = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (ren) begin
      rdata <= mem[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      total   <= TOTAL_RESET;
      count   <= CW'(1);
      next_id <= '0;
      ptr     <= '0;
      rd_vld  <= 1'b0;
      found   <= 1'b0;
    end else begin
      if (cfg_we) begin
        total <= cfg_data;
      end
      if (cmd.init) begin
        count <= CW'(1);
      end
      if (cmd.load) begin
        ptr    <= '0;
        rd_vld <= 1'b0;
        found  <= 1'b0;
        if (op == OP_ALLOC) begin
          next_id <= next_id + ID_W'(1);
        end
      end
      if (cmd.scan || cmd.down) begin
        rd_vld <= fwd_issue;
        if (fwd_issue) begin
          ptr <= ptr + CW'(1);
        end
      end
      if (cmd.up) begin
        rd_vld <= up_issue;
        if (up_issue) begin
          ptr <= ptr - CW'(1);
        end
      end
      if (cmd.up_init) begin
        ptr    <= count - CW'(1);
        rd_vld <= 1'b0;
      end
      if (cmd.fnext) begin
        ptr    <= CW'(k) + CW'(1) + CW'(nxt_free);
        rd_vld <= 1'b0;
      end
      if (take) begin
        found <= 1'b1;
      end
      if (cmd.split) begin
        count <= count + CW'(1);
      end
      if (down_done) begin
        count <= count - CW'(shift_d);
      end
    end
  end

  always_ff @(posedge clk) begin
    rd_idx <= ptr;
    if (cmd.load) begin
      op_free   <= (op == OP_FREE);
      req_sz    <= in_req;
      who       <= owner_id;
      rid       <= (op == OP_FREE) ? owner_id : next_id;
      prev_used <= 1'b1;
      granted_r <= '0;
    end
    if (take) begin
      best      <= rd_idx[PB-1:0];
      best_left <= rd_left;
    end
    if (cmd.scan && rd_vld && op_free && !match) begin
      prev_used <= rdata.used;
      prev_size <= rdata.size;
    end
    if (match) begin
      k         <= rd_idx[PB-1:0];
      prev_free <= !prev_used;
      acc       <= rdata.size + (prev_used ? '0 : prev_size);
    end
    if (cmd.fnext) begin
      acc     <= acc + (nxt_free ? rdata.size : '0);
      start   <= prev_free ? (k - PB'(1)) : k;
      shift_d <= {1'b0, prev_free} + {1'b0, nxt_free};
    end
    if (cmd.set_st) begin
      status_r <= cmd.st;
    end
    if (cmd.place) begin
      granted_r <= req_sz;
    end
    if (down_done) begin
      granted_r <= acc;
    end
    if (cmd.load_out) begin
      status       <= status_r;
      result_id    <= rid;
      granted_size <= FIELD_W'(granted_r);
    end
  end

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    (count != '0) && (count <= CW'(MAX_PARTS)))
    else $error("Partition count left its legal range.");

  a_split_room: assert property (@(posedge clk) disable iff (rst)
    cmd.split |-> (count < CW'(MAX_PARTS)))
    else $error("Split issued with a full table.");

  a_place_in_table: assert property (@(posedge clk) disable iff (rst)
    cmd.place |-> (CW'(best) < count))
    else $error("Allocated slot lies outside the table.");

endmodule

@@ hdl/wfpa_ctrl.sv @@
// Controller state machine of the allocator: sequences scan, shift, merge and response.
module wfpa_ctrl import wfpa_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  cfg_we,
  input  logic  in_valid,
  output logic  in_ready,
  output logic  out_valid,
  input  logic  out_ready,
  input  flag_t flag,
  output cmd_t  cmd
);

  typedef enum logic [10:0] {
    S_INIT  = 11'b00000000001,
    S_IDLE  = 11'b00000000010,
    S_SCAN  = 11'b00000000100,
    S_ADEC  = 11'b00000001000,
    S_UP    = 11'b00000010000,
    S_SPLIT = 11'b00000100000,
    S_PLACE = 11'b00001000000,
    S_FNEXT = 11'b00010000000,
    S_MERGE = 11'b00100000000,
    S_DOWN  = 11'b01000000000,
    S_RESP  = 11'b10000000000
  } state_t;

  state_t state;
  state_t state_next;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_INIT: begin
        cmd.init   = 1'b1;
        state_next = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          if (flag.in_zero) begin
            cmd.set_st = 1'b1;
            cmd.st     = ST_ZERO;
            state_next = S_RESP;
          end else begin
            state_next = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (flag.op_free) begin
          if (flag.match) begin
            state_next = S_FNEXT;
          end else if (flag.fwd_done) begin
            cmd.set_st = 1'b1;
            cmd.st     = ST_NO_ID;
            state_next = S_RESP;
          end
        end else if (flag.fwd_done) begin
          state_next = S_ADEC;
        end
      end
      S_ADEC: begin
        if (!flag.found) begin
          cmd.set_st = 1'b1;
          cmd.st     = ST_NO_FIT;
          state_next = S_RESP;
        end else if (flag.exact) begin
          state_next = S_PLACE;
        end else if (flag.full) begin
          cmd.set_st = 1'b1;
          cmd.st     = ST_FULL;
          state_next = S_RESP;
        end else begin
          cmd.up_init = 1'b1;
          state_next  = S_UP;
        end
      end
      S_UP: begin
        cmd.up = 1'b1;
        if (flag.up_done) begin
          state_next = S_SPLIT;
        end
      end
      S_SPLIT: begin
        cmd.split  = 1'b1;
        state_next = S_PLACE;
      end
      S_PLACE: begin
        cmd.place  = 1'b1;
        cmd.set_st = 1'b1;
        cmd.st     = ST_ALLOCATED;
        state_next = S_RESP;
      end
      S_FNEXT: begin
        cmd.fnext  = 1'b1;
        state_next = S_MERGE;
      end
      S_MERGE: begin
        cmd.merge  = 1'b1;
        state_next = S_DOWN;
      end
      S_DOWN: begin
        cmd.down = 1'b1;
        if (flag.fwd_done) begin
          cmd.set_st = 1'b1;
          cmd.st     = ST_FREED;
          state_next = S_RESP;
        end
      end
      S_RESP: begin
        if (!out_valid || out_ready) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_INIT;
      end
    endcase
    if (cfg_we) begin
      state_next = S_INIT;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_INIT;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && !cfg_we) |=> (state != S_IDLE))
    else $error("Accepted item did not start work.");

  a_split_then_place: assert property (@(posedge clk) disable iff (rst)
    (state == S_SPLIT && !cfg_we) |=> (state == S_PLACE))
    else $error("Split was not followed by placing the allocated piece.");

  a_cfg_reinit: assert property (@(posedge clk) disable iff (rst)
    cfg_we |=> (state == S_INIT))
    else $error("Configuration write did not reinitialize the table.");

endmodule

@@ hdl/worst_fit_partition_allocator.sv @@
// Top level of the worst-fit partition allocator with coalescing.
//
//   Channel  Kind         Fields                                Accepted when
//   cfg      write port   cfg_data (total_size)                 cfg_we high
//   req      valid/ready  op, request_size, owner_id            req.valid && req.ready
//   rsp      valid/ready  status, result_id, granted_size       rsp.valid && rsp.ready
//
// An allocate that splits scans the table with one memory read per cycle, then opens a slot
// with one read and one write per cycle. A free runs a scan to the owner, then a copy down.
// After reset or a total_size write, the init state writes slot zero before items are taken.
// The result waits in an output register; the next item is accepted meanwhile.
module worst_fit_partition_allocator import wfpa_pkg::*; #(
  parameter int MAX_PARTS = MAX_PARTS_DEF,
  parameter int SIZE_BITS = SIZE_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [FIELD_W-1:0] cfg_data,
  wfpa_req_if.sink           req,
  wfpa_rsp_if.source         rsp
);

  cmd_t  cmd;
  flag_t flag;

  wfpa_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .in_valid  (req.valid),
    .in_ready  (req.ready),
    .out_valid (rsp.valid),
    .out_ready (rsp.ready),
    .flag      (flag),
    .cmd       (cmd)
  );

  wfpa_dp #(
    .MAX_PARTS (MAX_PARTS),
    .SIZE_BITS (SIZE_BITS)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_data     (cfg_data),
    .op           (req.op),
    .request_size (req.request_size),
    .owner_id     (req.owner_id),
    .cmd          (cmd),
    .flag         (flag),
    .status       (rsp.status),
    .result_id    (rsp.result_id),
    .granted_size (rsp.granted_size)
  );

endmodule

@@ sim/worst_fit_partition_allocator_checker.sv @@
// Checker that predicts each allocator result from accepted items and compares it.
module worst_fit_partition_allocator_checker
  import wfpa_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [FIELD_W-1:0] cfg_data,
  wfpa_req_if                req,
  wfpa_rsp_if                rsp,
  output int                 failures,
  output int                 outstanding
);

  localparam int NPARTS = MAX_PARTS_DEF;

  typedef struct packed {
    status_t            status;
    logic [ID_W-1:0]    id;
    logic [FIELD_W-1:0] size;
  } outcome_t;

  logic [FIELD_W-1:0] mem_total;
  logic [FIELD_W-1:0] seg_size [NPARTS];
  bit                 seg_busy [NPARTS];
  logic [ID_W-1:0]    seg_owner [NPARTS];
  int                 seg_count;
  logic [ID_W-1:0]    id_next;
  outcome_t           pending_results [$];

  function automatic void clear_table();
    for (int i = 0; i < NPARTS; i++) begin
      seg_size[i] = '0;
      seg_busy[i] = 1'b0;
      seg_owner[i] = '0;
    end
    seg_size[0] = mem_total;
    seg_count = 1;
  endfunction

  function automatic void remove_seg(input int k);
    for (int i = k; i + 1 < seg_count; i++) begin
      seg_size[i] = seg_size[i + 1];
      seg_busy[i] = seg_busy[i + 1];
      seg_owner[i] = seg_owner[i + 1];
    end
    seg_count--;
    seg_size[seg_count] = '0;
    seg_busy[seg_count] = 1'b0;
    seg_owner[seg_count] = '0;
  endfunction

  function automatic outcome_t predict_alloc(input logic [FIELD_W-1:0] want);
    outcome_t           r;
    bit                 hit;
    int                 pick;
    logic [FIELD_W-1:0] spare;
    r.id = id_next;
    r.size = '0;
    id_next = id_next + ID_W'(1);
    hit = 1'b0;
    pick = 0;
    spare = '0;
    if (want == '0) begin
      r.status = ST_ZERO;
    end else begin
      for (int i = 0; i < seg_count; i++) begin
        if (!seg_busy[i] && seg_size[i] >= want &&
            (!hit || FIELD_W'(seg_size[i] - want) > spare)) begin
          hit = 1'b1;
          pick = i;
          spare = seg_size[i] - want;
        end
      end
      if (!hit) begin
        r.status = ST_NO_FIT;
      end else if (spare == '0) begin
        seg_busy[pick] = 1'b1;
        seg_owner[pick] = r.id;
        r.status = ST_ALLOCATED;
        r.size = want;
      end else if (seg_count >= NPARTS) begin
        r.status = ST_FULL;
      end else begin
        for (int i = seg_count; i > pick; i--) begin
          seg_size[i] = seg_size[i - 1];
          seg_busy[i] = seg_busy[i - 1];
          seg_owner[i] = seg_owner[i - 1];
        end
        seg_count++;
        seg_size[pick] = want;
        seg_busy[pick] = 1'b1;
        seg_owner[pick] = r.id;
        seg_size[pick + 1] = spare;
        r.status = ST_ALLOCATED;
        r.size = want;
      end
    end
    return r;
  endfunction

  // Only the lowest used partition with a matching owner is released.
  function automatic outcome_t predict_free(input logic [ID_W-1:0] who);
    outcome_t r;
    bit       hit;
    int       k;
    r.id = who;
    r.size = '0;
    hit = 1'b0;
    k = 0;
    for (int i = 0; i < seg_count; i++) begin
      if (!hit && seg_busy[i] && seg_owner[i] == who) begin
        hit = 1'b1;
        k = i;
      end
    end
    if (!hit) begin
      r.status = ST_NO_ID;
    end else begin
      seg_busy[k] = 1'b0;
      seg_owner[k] = '0;
      if (k + 1 < seg_count && !seg_busy[k + 1]) begin
        seg_size[k] = seg_size[k] + seg_size[k + 1];
        remove_seg(k + 1);
      end
      if (k > 0 && !seg_busy[k - 1]) begin
        seg_size[k - 1] = seg_size[k - 1] + seg_size[k];
        remove_seg(k);
        k--;
      end
      r.status = ST_FREED;
      r.size = seg_size[k];
    end
    return r;
  endfunction

  always @(posedge clk) begin
    outcome_t want;
    if (rst) begin
      mem_total = TOTAL_RESET;
      id_next = '0;
      clear_table();
      pending_results.delete();
      failures = 0;
    end else begin
      if (cfg_we) begin
        mem_total = cfg_data;
        clear_table();
      end
      if (rsp.valid && rsp.ready) begin
        if (pending_results.size() == 0) begin
          $error("result with no item outstanding: status %0d id %0d granted_size %0d",
                 rsp.status, rsp.result_id, rsp.granted_size);
          failures++;
        end else begin
          want = pending_results.pop_front();
          if (rsp.status !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, rsp.status);
            failures++;
          end
          if (rsp.result_id !== want.id) begin
            $error("result_id: expected %0d, actual %0d", want.id, rsp.result_id);
            failures++;
          end
          if (rsp.granted_size !== want.size) begin
            $error("granted_size: expected %0d, actual %0d", want.size, rsp.granted_size);
            failures++;
          end
        end
      end
      if (req.valid && req.ready) begin
        if (req.op == OP_FREE) pending_results.push_back(predict_free(req.owner_id));
        else pending_results.push_back(predict_alloc(req.request_size));
      end
    end
    outstanding = pending_results.size();
  end

endmodule

@@ sim/worst_fit_partition_allocator_test.sv @@
// Testbench top that drives allocate and free items into the allocator and reports the verdict.
module worst_fit_partition_allocator_test;
  import wfpa_pkg::*;

  localparam int CYCLE_LIMIT = 10_000_000;
  localparam int DRAIN_CYCLES = 40;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               cfg_we = 1'b0;
  logic [FIELD_W-1:0] cfg_data = '0;
  int                 failures;
  int                 outstanding;
  longint             cycles = 0;
  bit                 req_gaps_on = 1'b1;
  bit                 rsp_stalls_on = 1'b1;
  logic [ID_W-1:0]    id_count = '0;
  logic [ID_W-1:0]    live_ids [$];

  wfpa_req_if req ();
  wfpa_rsp_if rsp ();

  worst_fit_partition_allocator dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .req      (req),
    .rsp      (rsp)
  );

  worst_fit_partition_allocator_checker checker_inst (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_data    (cfg_data),
    .req         (req),
    .rsp         (rsp),
    .failures    (failures),
    .outstanding (outstanding)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 45) return 0;
    if (roll < 85) return $urandom_range(1, 3);
    if (roll < 96) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  initial begin
    int run;
    int hold;
    rsp.ready = 1'b0;
    @(negedge clk);
    forever begin
      run = $urandom_range(1, 24);
      if ($urandom_range(0, 9) == 0) run = $urandom_range(50, 200);
      rsp.ready <= 1'b1;
      repeat (run) @(negedge clk);
      hold = rsp_stalls_on ? pick_gap() : 0;
      if (hold > 0) begin
        rsp.ready <= 1'b0;
        repeat (hold) @(negedge clk);
      end
    end
  end

  task automatic send_item(input op_t op, input logic [FIELD_W-1:0] size,
                           input logic [ID_W-1:0] who);
    int gap;
    req.valid <= 1'b1;
    req.op <= op;
    req.request_size <= size;
    req.owner_id <= who;
    do @(posedge clk); while (!req.ready);
    @(negedge clk);
    gap = req_gaps_on ? pick_gap() : 0;
    if (gap > 0) begin
      req.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  // Every allocate consumes an id, whatever its status.
  task automatic alloc(input logic [FIELD_W-1:0] size, output logic [ID_W-1:0] id);
    id = id_count;
    id_count = id_count + ID_W'(1);
    send_item(OP_ALLOC, size, ID_W'($urandom));
  endtask

  task automatic free_id(input logic [ID_W-1:0] who);
    send_item(OP_FREE, FIELD_W'($urandom), who);
  endtask

  task automatic set_total(input logic [FIELD_W-1:0] value);
    req.valid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    cfg_we <= 1'b1;
    cfg_data <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    live_ids.delete();
  endtask

  task automatic random_phase(input logic [FIELD_W-1:0] total, input int count);
    logic [FIELD_W-1:0] size;
    logic [ID_W-1:0]    id;
    int                 pick;
    int                 roll;
    set_total(total);
    repeat (count) begin
      roll = $urandom_range(0, 99);
      if (roll < 50) begin
        // Power-of-two fractions of the memory, mixed with random sizes, make exact fits likely after merges.
        case ($urandom_range(0, 3))
          0: size = total >> $urandom_range(1, 5);
          1: size = FIELD_W'($urandom_range(1, (total > 4) ? total / 4 : 1));
          2: size = FIELD_W'($urandom_range(1, 8));
          default: size = total >> $urandom_range(3, 4);
        endcase
        if (size == '0) size = FIELD_W'(1);
        alloc(size, id);
        live_ids.push_back(id);
      end else if (roll < 88 && live_ids.size() > 0) begin
        pick = $urandom_range(0, live_ids.size() - 1);
        id = live_ids[pick];
        live_ids.delete(pick);
        free_id(id);
      end else if (roll < 94) begin
        alloc(FIELD_W'($urandom), id);
      end else if (roll < 97) begin
        alloc('0, id);
      end else begin
        free_id(ID_W'($urandom));
      end
    end
  endtask

  initial begin
    logic [ID_W-1:0] id;
    logic [ID_W-1:0] id_a;
    logic [ID_W-1:0] id_b;
    logic [ID_W-1:0] held [15];
    req.valid = 1'b0;
    req.op = OP_ALLOC;
    req.request_size = '0;
    req.owner_id = '0;
    repeat (4) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    alloc('0, id);
    alloc(16'hFFFF, id);
    alloc(16'd1024, id_a);
    alloc(16'd3072, id_b);
    alloc(16'd1, id);
    free_id(id_a);
    free_id(id_a);
    free_id(16'hFFFF);
    free_id(id_b);
    for (int i = 0; i < 15; i++) alloc(16'd200, held[i]);
    alloc(16'd100, id);
    alloc(16'd1096, id);
    free_id(held[5]);
    free_id(held[4]);
    free_id(held[6]);
    set_total('0);
    alloc(16'd1, id);
    alloc('0, id);
    free_id('0);

    random_phase(16'd4096, 260);
    random_phase(16'd64, 220);
    random_phase(16'hFFFF, 260);
    random_phase(16'd16, 200);
    random_phase(16'd1, 60);
    random_phase(16'd300, 200);
    random_phase('0, 40);
    random_phase(16'd1000, 200);
    random_phase(16'd4096, 260);

    req.valid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (failures == 0 && outstanding == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
hdl/wfpa_pkg.sv
hdl/wfpa_req_if.sv
hdl/wfpa_rsp_if.sv
hdl/wfpa_dp.sv
hdl/wfpa_ctrl.sv
hdl/worst_fit_partition_allocator.sv
sim/worst_fit_partition_allocator_checker.sv
sim/worst_fit_partition_allocator_test.sv
